// ===== src/internet_checksum_word_stream_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the internet checksum word stream core.
// Each macro expands to one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef INTERNET_CHECKSUM_WORD_STREAM_CORE_ASSERT_SVH
`define INTERNET_CHECKSUM_WORD_STREAM_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ICS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ICS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ics_pkg.sv =====
// ----------------------------------------------------------------------------
// ics_pkg
// Shared widths, stage types and arithmetic helpers of the checksum core.
// ----------------------------------------------------------------------------
package ics_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 3;
  localparam int HALF_W  = 16;

  localparam logic [COUNT_W-1:0] CNT_NONE  = 3'd0;
  localparam logic [COUNT_W-1:0] CNT_ONE   = 3'd1;
  localparam logic [COUNT_W-1:0] CNT_TWO   = 3'd2;
  localparam logic [COUNT_W-1:0] CNT_THREE = 3'd3;

  typedef struct packed {
    logic               vld;
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] count;
    logic               last;
  } ics_beat_t;

  typedef struct packed {
    logic              vld;
    logic [WORD_W-1:0] sum;
  } ics_fin_t;

  function automatic logic [WORD_W-1:0] keep_bytes(input logic [WORD_W-1:0] w,
                                                   input logic [COUNT_W-1:0] c);
    logic [WORD_W-1:0] k;
    case (c)
      CNT_NONE:  k = '0;
      CNT_ONE:   k = {24'h0, w[7:0]};
      CNT_TWO:   k = {16'h0, w[15:0]};
      CNT_THREE: k = {8'h0, w[23:0]};
      default:   k = w;
    endcase
    return k;
  endfunction

  function automatic logic [WORD_W-1:0] ones_add32(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
    logic [WORD_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, t[WORD_W]};
  endfunction

  function automatic logic [HALF_W-1:0] fold16(input logic [WORD_W-1:0] s);
    logic [HALF_W:0] f;
    f = {1'b0, s[HALF_W-1:0]} + {1'b0, s[WORD_W-1:HALF_W]};
    return f[HALF_W-1:0] + {{(HALF_W-1){1'b0}}, f[HALF_W]};
  endfunction

endpackage

// ===== src/ics_stream_if.sv =====
// ----------------------------------------------------------------------------
// ics_stream_if
// Valid/ready channels of the checksum core: word input and checksum output.
// ----------------------------------------------------------------------------
interface ics_in_if;
  logic                        valid;
  logic                        ready;
  logic [ics_pkg::WORD_W-1:0]  data_word;
  logic [ics_pkg::COUNT_W-1:0] byte_count;
  logic                        last_word;

  modport source (output valid, output data_word, output byte_count,
                  output last_word, input ready);
  modport sink (input valid, input data_word, input byte_count,
                input last_word, output ready);
endinterface

interface ics_out_if;
  logic                       valid;
  logic                       ready;
  logic [ics_pkg::HALF_W-1:0] checksum;

  modport source (output valid, output checksum, input ready);
  modport sink (input valid, input checksum, output ready);
endinterface

// ===== src/ics_sum_stage.sv =====
// ----------------------------------------------------------------------------
// ics_sum_stage
// One's-complement accumulator: adds each registered word and hands the
// packet's final sum on at the last word.
// ----------------------------------------------------------------------------
`include "internet_checksum_word_stream_core_assert.svh"

module ics_sum_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  ics_pkg::ics_beat_t beat,
  output ics_pkg::ics_fin_t  fin
);
  import ics_pkg::*;

  logic [WORD_W-1:0] acc_r;
  logic [WORD_W-1:0] acc_nxt;
  logic [WORD_W-1:0] sum;
  ics_fin_t          fin_r;
  ics_fin_t          fin_nxt;

  always_comb begin
    sum         = ones_add32(acc_r, keep_bytes(beat.word, beat.count));
    acc_nxt     = acc_r;
    fin_nxt.vld = beat.vld & beat.last;
    fin_nxt.sum = sum;
    if (beat.vld) begin
      acc_nxt = beat.last ? '0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      fin_r.vld <= 1'b0;
    end else if (adv) begin
      acc_r     <= acc_nxt;
      fin_r.vld <= fin_nxt.vld;
    end
    if (adv) begin
      fin_r.sum <= fin_nxt.sum;
    end
  end

  assign fin = fin_r;

  `ICS_ASSERT_NEXT(a_clear_after_last, clk, rst_n, adv && beat.vld && beat.last,
                   acc_r == '0, "accumulator not cleared after last word")
  `ICS_ASSERT_NEXT(a_fin_only_on_last, clk, rst_n, adv && !(beat.vld && beat.last),
                   !fin_r.vld, "final sum raised without a last word")
  `ICS_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, !adv,
                   $stable(acc_r) && $stable(fin_r), "sum stage moved during a stall")

endmodule

// ===== src/internet_checksum_word_stream_core.sv =====
// ----------------------------------------------------------------------------
// internet_checksum_word_stream_core
// Internet checksum over a stream of little-endian 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   in_beat carries one word per beat with its valid byte count and a
//   last-word flag; pseudo-header words are simply sent ahead of the payload.
//   out_beat carries one 16-bit checksum per packet, on its last word.
// Path: a checksum moves from the packet's last word through the input
//   register, the sum stage and the output register.
// Throughput: one word per cycle while no pending checksum is stalled.
// Reset clears the running sum and all stage valid bits.
// When the receiver stalls a pending checksum, the whole pipeline holds and
//   in_beat.ready drops in the same cycle; it rises again as soon as the
//   checksum beat is taken.
// ----------------------------------------------------------------------------
module internet_checksum_word_stream_core (
  input  logic clk,
  input  logic rst_n,
  ics_in_if.sink    in_beat,
  ics_out_if.source out_beat
);
  import ics_pkg::*;

  logic              adv;
  ics_beat_t         beat_r;
  ics_fin_t          fin;
  logic              out_vld_r;
  logic [HALF_W-1:0] checksum_r;
  logic [HALF_W-1:0] checksum_nxt;

  assign adv           = !out_vld_r || out_beat.ready;
  assign in_beat.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.vld <= 1'b0;
    end else if (adv) begin
      beat_r.vld <= in_beat.valid;
    end
    if (adv) begin
      beat_r.word  <= in_beat.data_word;
      beat_r.count <= in_beat.byte_count;
      beat_r.last  <= in_beat.last_word;
    end
  end

  ics_sum_stage u_sum (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .beat  (beat_r),
    .fin   (fin)
  );

  assign checksum_nxt = ~fold16(fin.sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= fin.vld;
    end
    if (adv) begin
      checksum_r <= checksum_nxt;
    end
  end

  assign out_beat.valid    = out_vld_r;
  assign out_beat.checksum = checksum_r;

endmodule

// ===== tb/internet_checksum_word_stream_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// internet_checksum_word_stream_core_tb
// Self-checking bench for the word-stream internet checksum core. A directed
// table of words covers byte-count tails, zero and oversized counts, carry
// wrap and empty packets. Random packets follow, with random gaps on the
// word side and random stalls on the checksum side. Every checksum beat is
// compared with a table value or the bench's own running one's-complement sum.
// ----------------------------------------------------------------------------
module internet_checksum_word_stream_core_tb;
  import ics_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int NUM_DIRECTED = 22;
  localparam int NUM_RANDOM   = 2000;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] count;
    logic               last;
    logic               known;
    logic [HALF_W-1:0]  sum;
  } word_row_t;

  word_row_t dir_rows [NUM_DIRECTED] = '{
    '{32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, 16'hFFFF},
    '{32'h1234_5678, 3'd1, 1'b1, 1'b1, 16'hFF87},
    '{32'h1234_5678, 3'd2, 1'b1, 1'b1, 16'hA987},
    '{32'h1234_5678, 3'd3, 1'b1, 1'b1, 16'hA953},
    '{32'hFFFF_FFFF, 3'd4, 1'b1, 1'b1, 16'h0000},
    '{32'h0000_0000, 3'd4, 1'b1, 1'b1, 16'hFFFF},
    '{32'h0001_0002, 3'd5, 1'b1, 1'b1, 16'hFFFC},
    '{32'h0001_0002, 3'd6, 1'b1, 1'b1, 16'hFFFC},
    '{32'h0001_0002, 3'd7, 1'b1, 1'b1, 16'hFFFC},
    '{32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, 16'h0000},
    '{32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, 16'h0000},
    '{32'h0000_0001, 3'd4, 1'b1, 1'b0, 16'h0000},
    '{32'hAAAA_AAAA, 3'd0, 1'b0, 1'b0, 16'h0000},
    '{32'h8000_0000, 3'd4, 1'b0, 1'b0, 16'h0000},
    '{32'h8000_0000, 3'd4, 1'b0, 1'b0, 16'h0000},
    '{32'h0000_FFFF, 3'd2, 1'b1, 1'b0, 16'h0000},
    '{32'hDEAD_BEEF, 3'd3, 1'b0, 1'b0, 16'h0000},
    '{32'hCAFE_F00D, 3'd1, 1'b0, 1'b0, 16'h0000},
    '{32'h0102_0304, 3'd4, 1'b1, 1'b0, 16'h0000},
    '{32'h0000_0000, 3'd0, 1'b1, 1'b1, 16'hFFFF},
    '{32'h0000_1234, 3'd4, 1'b0, 1'b0, 16'h0000},
    '{32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, 16'hEDCB}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  ics_in_if  words_ch ();
  ics_out_if sums_ch ();

  internet_checksum_word_stream_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (words_ch),
    .out_beat (sums_ch)
  );

  logic [WORD_W-1:0] acc_sum;
  logic [HALF_W-1:0] checksum_q [$];
  logic [HALF_W-1:0] want_sum;
  int unsigned       error_count = 0;
  int unsigned       idle_cycles = 0;
  int unsigned       stall_left = 0;
  bit                quiet = 1'b0;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [WORD_W-1:0] masked_word(input logic [WORD_W-1:0] w,
                                                    input logic [COUNT_W-1:0] c);
    if (c >= 3'd4) begin
      return w;
    end
    return w & ({WORD_W{1'b1}} >> (8 * (4 - c)));
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'(($urandom()))};
      default: return $urandom();
    endcase
  endfunction

  // Fold the accepted word into the running sum; on a last word, queue the
  // complemented 16-bit fold (or the row's known sum) and start a fresh packet.
  function automatic void absorb_word(input word_row_t r);
    logic [WORD_W:0]   t;
    logic [HALF_W:0]   f;
    logic [HALF_W-1:0] cs;
    t = {1'b0, acc_sum} + {1'b0, masked_word(r.word, r.count)};
    acc_sum = t[WORD_W] ? t[WORD_W-1:0] + 1'b1 : t[WORD_W-1:0];
    if (r.last) begin
      f = {1'b0, acc_sum[HALF_W-1:0]} + {1'b0, acc_sum[WORD_W-1:HALF_W]};
      cs = f[HALF_W] ? f[HALF_W-1:0] + 1'b1 : f[HALF_W-1:0];
      checksum_q.push_back(r.known ? r.sum : ~cs);
      acc_sum = '0;
    end
  endfunction

  task automatic send_word(input word_row_t r);
    int unsigned n;
    words_ch.valid      <= 1'b1;
    words_ch.data_word  <= r.word;
    words_ch.byte_count <= r.count;
    words_ch.last_word  <= r.last;
    do @(posedge clk); while (!words_ch.ready);
    absorb_word(r);
    n = idle_len();
    if (n != 0) begin
      words_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || stall_left != 0) begin
      sums_ch.ready <= 1'b0;
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end
    end else begin
      sums_ch.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_left <= idle_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((words_ch.valid && words_ch.ready) || (sums_ch.valid && sums_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("internet_checksum_word_stream_core_tb failed");
        $finish;
      end
      if (sums_ch.valid && sums_ch.ready) begin
        if (checksum_q.size() == 0) begin
          $error("checksum: no beat expected, actual %h", sums_ch.checksum);
          error_count++;
        end else begin
          want_sum = checksum_q.pop_front();
          if (sums_ch.checksum !== want_sum) begin
            $error("checksum: expected %h, actual %h", want_sum, sums_ch.checksum);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned len;
    word_row_t   r;
    words_ch.valid      = 1'b0;
    words_ch.data_word  = '0;
    words_ch.byte_count = '0;
    words_ch.last_word  = 1'b0;
    acc_sum             = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_word(dir_rows[i]);
    end

    // Mostly well-formed packets; now and then a stray count or a lost or
    // extra last flag.
    sent = 0;
    while (sent < NUM_RANDOM) begin
      if ($urandom_range(0, 9) == 0) begin
        quiet = ~quiet;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        r.word  = random_word();
        r.count = 3'd4;
        r.last  = (k == len - 1);
        r.known = 1'b0;
        r.sum   = '0;
        if (r.last && $urandom_range(0, 1) == 1) begin
          r.count = COUNT_W'($urandom_range(1, 4));
        end
        if ($urandom_range(0, 19) == 0) begin
          r.count = COUNT_W'($urandom_range(0, 7));
        end
        if ($urandom_range(0, 49) == 0) begin
          r.last = ~r.last;
        end
        send_word(r);
        sent++;
      end
    end
    r.word  = random_word();
    r.count = 3'd4;
    r.last  = 1'b1;
    r.known = 1'b0;
    r.sum   = '0;
    send_word(r);
    words_ch.valid <= 1'b0;

    while (checksum_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("internet_checksum_word_stream_core_tb passed");
    end else begin
      $display("internet_checksum_word_stream_core_tb failed");
    end
    $finish;
  end

endmodule
